@@ rtl/core/acs_pkg.sv @@
package acs_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned FORM_W = 16;

  localparam logic [CP_W-1:0] LAM_CP = 21'h000644;
  localparam logic [CP_W-1:0] ALEF_MADDA_CP = 21'h000622;
  localparam logic [CP_W-1:0] ALEF_HAMZA_ABOVE_CP = 21'h000623;
  localparam logic [CP_W-1:0] ALEF_HAMZA_BELOW_CP = 21'h000625;
  localparam logic [CP_W-1:0] ALEF_CP = 21'h000627;
  localparam logic [FORM_W-1:0] HAMZA_ISOLATED = 16'hFE80;
  localparam logic [FORM_W-1:0] LIGATURE_FIRST = 16'hFEF5;

  // joining class; LC_NOT means the code point is not in the letter table
  typedef enum logic [1:0] {
    LC_NOT,
    LC_NONE,
    LC_RIGHT,
    LC_DUAL
  } letter_cls_e;

  typedef struct packed {
    letter_cls_e       cls;
    logic [FORM_W-1:0] iso;
  } letter_t;

  // one queue beat per accepted input item
  typedef struct packed {
    logic            emit_held;  // held code point is resolved by this item
    logic            is_lig;     // held lam merges with this alef variant
    logic [1:0]      lig_idx;
    logic            held_prev;  // code point before the held one is dual-joining
    logic            next_acc;   // this item accepts a join from the held one
    logic [CP_W-1:0] held_code;
    logic            emit_cur;   // item closes its string and is shaped at once
    logic            cur_prev;
    logic            last;
    logic [CP_W-1:0] code;
  } acs_entry_t;

  // forms sit at iso, fin = iso+1, ini = iso+2, med = iso+3; ini/med only if dual
  function automatic letter_t letter_info(input logic [CP_W-1:0] cp);
    letter_t r;
    r.cls = LC_NOT;
    r.iso = '0;
    case (cp)
      21'h000621: begin r.cls = LC_NONE;  r.iso = HAMZA_ISOLATED; end
      21'h000622: begin r.cls = LC_RIGHT; r.iso = 16'hFE81; end
      21'h000623: begin r.cls = LC_RIGHT; r.iso = 16'hFE83; end
      21'h000624: begin r.cls = LC_RIGHT; r.iso = 16'hFE85; end
      21'h000625: begin r.cls = LC_RIGHT; r.iso = 16'hFE87; end
      21'h000626: begin r.cls = LC_DUAL;  r.iso = 16'hFE89; end
      21'h000627: begin r.cls = LC_RIGHT; r.iso = 16'hFE8D; end
      21'h000628: begin r.cls = LC_DUAL;  r.iso = 16'hFE8F; end
      21'h000629: begin r.cls = LC_RIGHT; r.iso = 16'hFE93; end
      21'h00062A: begin r.cls = LC_DUAL;  r.iso = 16'hFE95; end
      21'h00062B: begin r.cls = LC_DUAL;  r.iso = 16'hFE99; end
      21'h00062C: begin r.cls = LC_DUAL;  r.iso = 16'hFE9D; end
      21'h00062D: begin r.cls = LC_DUAL;  r.iso = 16'hFEA1; end
      21'h00062E: begin r.cls = LC_DUAL;  r.iso = 16'hFEA5; end
      21'h00062F: begin r.cls = LC_RIGHT; r.iso = 16'hFEA9; end
      21'h000630: begin r.cls = LC_RIGHT; r.iso = 16'hFEAB; end
      21'h000631: begin r.cls = LC_RIGHT; r.iso = 16'hFEAD; end
      21'h000632: begin r.cls = LC_RIGHT; r.iso = 16'hFEAF; end
      21'h000633: begin r.cls = LC_DUAL;  r.iso = 16'hFEB1; end
      21'h000634: begin r.cls = LC_DUAL;  r.iso = 16'hFEB5; end
      21'h000635: begin r.cls = LC_DUAL;  r.iso = 16'hFEB9; end
      21'h000636: begin r.cls = LC_DUAL;  r.iso = 16'hFEBD; end
      21'h000637: begin r.cls = LC_DUAL;  r.iso = 16'hFEC1; end
      21'h000638: begin r.cls = LC_DUAL;  r.iso = 16'hFEC5; end
      21'h000639: begin r.cls = LC_DUAL;  r.iso = 16'hFEC9; end
      21'h00063A: begin r.cls = LC_DUAL;  r.iso = 16'hFECD; end
      21'h000641: begin r.cls = LC_DUAL;  r.iso = 16'hFED1; end
      21'h000642: begin r.cls = LC_DUAL;  r.iso = 16'hFED5; end
      21'h000643: begin r.cls = LC_DUAL;  r.iso = 16'hFED9; end
      21'h000644: begin r.cls = LC_DUAL;  r.iso = 16'hFEDD; end
      21'h000645: begin r.cls = LC_DUAL;  r.iso = 16'hFEE1; end
      21'h000646: begin r.cls = LC_DUAL;  r.iso = 16'hFEE5; end
      21'h000647: begin r.cls = LC_DUAL;  r.iso = 16'hFEE9; end
      21'h000648: begin r.cls = LC_RIGHT; r.iso = 16'hFEED; end
      21'h000649: begin r.cls = LC_RIGHT; r.iso = 16'hFEEF; end
      21'h00064A: begin r.cls = LC_DUAL;  r.iso = 16'hFEF1; end
      default: begin r.cls = LC_NOT; r.iso = '0; end
    endcase
    return r;
  endfunction

  function automatic logic is_dual(input logic [CP_W-1:0] cp);
    letter_t r;
    r = letter_info(cp);
    return r.cls == LC_DUAL;
  endfunction

  function automatic logic accepts_join(input logic [CP_W-1:0] cp);
    letter_t r;
    r = letter_info(cp);
    return (r.cls == LC_RIGHT) || (r.cls == LC_DUAL);
  endfunction

  // next_acc already folds in whether a successor exists
  function automatic logic [CP_W-1:0] shape(input logic [CP_W-1:0] cp,
                                            input logic prev_dual,
                                            input logic next_acc);
    letter_t r;
    logic jp;
    logic jn;
    logic [FORM_W-1:0] g;
    r = letter_info(cp);
    jp = prev_dual && (r.cls == LC_RIGHT || r.cls == LC_DUAL);
    jn = next_acc && (r.cls == LC_DUAL);
    if (jp && jn) begin
      g = r.iso + 16'd3;
    end else if (jp) begin
      g = r.iso + 16'd1;
    end else if (jn) begin
      g = r.iso + 16'd2;
    end else begin
      g = r.iso;
    end
    if (r.cls == LC_NOT) begin
      return cp;
    end
    return {{(CP_W-FORM_W){1'b0}}, g};
  endfunction

endpackage

@@ rtl/core/acs_front.sv @@
module acs_front import acs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CP_W-1:0] code_point_i,
  input  logic            last_in_string_i,
  input  logic            q_full_i,
  output logic            push_o,
  output acs_entry_t      entry_o
);

  logic [CP_W-1:0] held_code_q, held_code_d;
  logic            held_valid_q, held_valid_d;
  logic            prev_dual_q, prev_dual_d;
  logic            lig_hit;
  logic [1:0]      lig_idx;
  logic            mid_prev;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    lig_hit = 1'b1;
    lig_idx = 2'd0;
    case (code_point_i)
      ALEF_MADDA_CP:       lig_idx = 2'd0;
      ALEF_HAMZA_ABOVE_CP: lig_idx = 2'd1;
      ALEF_HAMZA_BELOW_CP: lig_idx = 2'd2;
      ALEF_CP:             lig_idx = 2'd3;
      default:             lig_hit = 1'b0;
    endcase
    lig_hit = lig_hit && held_valid_q && (held_code_q == LAM_CP);
  end

  always_comb begin
    mid_prev = held_valid_q ? is_dual(held_code_q) : prev_dual_q;

    entry_o.emit_held = held_valid_q;
    entry_o.is_lig    = lig_hit;
    entry_o.lig_idx   = lig_idx;
    entry_o.held_prev = prev_dual_q;
    entry_o.next_acc  = accepts_join(code_point_i);
    entry_o.held_code = held_code_q;
    entry_o.emit_cur  = last_in_string_i && !lig_hit;
    entry_o.cur_prev  = mid_prev;
    entry_o.last      = last_in_string_i;
    entry_o.code      = code_point_i;

    held_code_d  = held_code_q;
    held_valid_d = held_valid_q;
    prev_dual_d  = prev_dual_q;
    if (push_o) begin
      if (lig_hit) begin
        // the alef becomes the previous code point for what follows
        held_code_d  = '0;
        held_valid_d = 1'b0;
        prev_dual_d  = last_in_string_i ? 1'b0 : is_dual(code_point_i);
      end else if (last_in_string_i) begin
        held_code_d  = '0;
        held_valid_d = 1'b0;
        prev_dual_d  = 1'b0;
      end else begin
        held_code_d  = code_point_i;
        held_valid_d = 1'b1;
        prev_dual_d  = mid_prev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_code_q  <= '0;
      held_valid_q <= 1'b0;
      prev_dual_q  <= 1'b0;
    end else begin
      held_code_q  <= held_code_d;
      held_valid_q <= held_valid_d;
      prev_dual_q  <= prev_dual_d;
    end
  end

endmodule

@@ rtl/core/acs_queue.sv @@
module acs_queue import acs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  acs_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output acs_entry_t head_o
);

  acs_entry_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/acs_back.sv @@
module acs_back import acs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  acs_entry_t      head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CP_W-1:0] glyph_code_o,
  output logic            end_of_string_o
);

  logic            phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic [CP_W-1:0] glyph_q, glyph_d;
  logic            eos_q, eos_d;
  logic            can_load;
  logic            now_held;
  logic            has_result;
  logic            load;
  logic [FORM_W-1:0] lig_glyph;

  assign out_valid_o     = out_valid_q;
  assign glyph_code_o    = glyph_q;
  assign end_of_string_o = eos_q;

  always_comb begin
    can_load   = !out_valid_q || out_ready_i;
    now_held   = head_valid_i && head_i.emit_held && !phase_q;
    has_result = head_valid_i && (now_held || head_i.emit_cur);
    load       = has_result && can_load;
    // entries with no result drain without an output slot
    pop_o      = head_valid_i && (!has_result || (load && !(now_held && head_i.emit_cur)));

    lig_glyph = LIGATURE_FIRST + {13'd0, head_i.lig_idx, 1'b0}
              + {15'd0, head_i.held_prev};

    if (now_held) begin
      glyph_d = head_i.is_lig ? {{(CP_W-FORM_W){1'b0}}, lig_glyph}
                              : shape(head_i.held_code, head_i.held_prev, head_i.next_acc);
      eos_d   = head_i.is_lig && head_i.last;
    end else begin
      glyph_d = shape(head_i.code, head_i.cur_prev, 1'b0);
      eos_d   = 1'b1;
    end

    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);

    phase_d = phase_q;
    if (load && now_held && head_i.emit_cur) begin
      phase_d = 1'b1;
    end else if (pop_o) begin
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      glyph_q <= glyph_d;
      eos_q   <= eos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q |-> head_valid_i)
    else $error("second result pending without a queue entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q |-> (head_i.emit_held && head_i.emit_cur))
    else $error("second result phase on a single-result entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop_o && !load) |-> !(head_i.emit_held || head_i.emit_cur))
    else $error("entry dropped with results still owed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head_i.is_lig && head_valid_i) |-> !head_i.emit_cur)
    else $error("ligature entry also flags a trailing result");

endmodule

@@ rtl/core/arabic_contextual_shaper_unit.sv @@
// arabic contextual shaper
// input channel: one logical code point per beat (code_point_i) with
// last_in_string_i on the final beat of a string. output channel: one shaped
// glyph per beat (glyph_code_o) with end_of_string_o on the string's last one.
// a code point is held until its successor arrives, so its glyph leaves only
// once the next beat (or the end of string) is seen; a lam followed by an
// alef variant leaves as one ligature glyph. a string-ending beat can yield
// two glyphs, the held one and its own.
// the front stage classifies each accepted beat into a two-entry queue; the
// back stage looks up the presentation form and fills the output register.
// the beat that resolves a glyph is written into the queue, and the back
// stage then loads the glyph into the output register. the back stage
// retires at most one queue entry per cycle: a beat that leaves no glyph
// (the first of a string) still takes a turn, a string end with two glyphs
// holds its entry for both, so a gapless sender sees the input stall.
// in_ready_o drops only when the queue is full, so a stalled receiver backs
// up through the output register and the queue before the input stalls.
// reset clears the held code point, the joining context, the queue and the
// output register; the first beat after reset starts a new string.
module arabic_contextual_shaper_unit import acs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CP_W-1:0] code_point_i,
  input  logic            last_in_string_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CP_W-1:0] glyph_code_o,
  output logic            end_of_string_o
);

  logic       q_full;
  logic       push;
  acs_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  acs_entry_t head;

  acs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .code_point_i     (code_point_i),
    .last_in_string_i (last_in_string_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  acs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  acs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .glyph_code_o    (glyph_code_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import acs_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] glyph;
    logic            eos;
  } glyph_beat_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
    logic            has_want;
    logic [CP_W-1:0] glyph;
    logic            eos;
  } stim_row_t;

  localparam logic [CP_W-1:0] FIRST_LETTER_CP = 21'h000621;
  localparam logic [CP_W-1:0] LAST_LETTER_CP = 21'h00064A;
  localparam int PHASE_ITEMS = 312;
  localparam int HOLD_CYCLES = 60;
  localparam int SRC_PCT [0:3] = '{0, 60, 0, 32};
  localparam int SNK_PCT [0:3] = '{0, 0, 60, 32};

  // glyph is typed in only for single-glyph rows that read off directly
  localparam stim_row_t DIRECTED [0:24] = '{
    '{21'h000628, 1'b1, 1'b1, 21'h00FE8F, 1'b1},
    '{21'h000000, 1'b1, 1'b1, 21'h000000, 1'b1},
    '{21'h1FFFFF, 1'b1, 1'b1, 21'h1FFFFF, 1'b1},
    '{21'h000621, 1'b1, 1'b1, 21'h00FE80, 1'b1},
    '{21'h000644, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000627, 1'b1, 1'b1, 21'h00FEFB, 1'b1},
    '{21'h000628, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h00064A, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h00062A, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{21'h000628, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000644, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000622, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000628, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{21'h000644, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000623, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000644, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000625, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{21'h000633, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000621, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000648, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000649, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{21'h000644, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h00063B, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h000640, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{21'h00064B, 1'b1, 1'b0, 21'h000000, 1'b0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [CP_W-1:0] code_point_i = '0;
  logic            last_in_string_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [CP_W-1:0] glyph_code_o;
  logic            end_of_string_o;

  arabic_contextual_shaper_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_point_i    (code_point_i),
    .last_in_string_i(last_in_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .glyph_code_o    (glyph_code_o),
    .end_of_string_o (end_of_string_o)
  );

  // letter forms, indexed from the first table letter; gaps stay LC_NOT
  letter_t         letter_rom [0:41];
  logic [CP_W-1:0] letter_bases [$];

  // shaper context as the block should hold it
  logic [CP_W-1:0] held_cp = '0;
  logic            held_busy = 1'b0;
  logic            prev_joins = 1'b0;

  glyph_beat_t     expected_glyphs [$];
  int              mismatches = 0;
  int              src_idle_pct = 0;
  int              snk_stall_pct = 0;
  int              hold_req = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic rom_row(input logic [CP_W-1:0] base, input letter_cls_e cls,
                         input logic [15:0] iso);
    letter_rom[base - FIRST_LETTER_CP].cls = cls;
    letter_rom[base - FIRST_LETTER_CP].iso = iso;
  endtask

  function automatic letter_t row_of(input logic [CP_W-1:0] cp);
    letter_t r;
    r.cls = LC_NOT;
    r.iso = '0;
    if (cp >= FIRST_LETTER_CP && cp <= LAST_LETTER_CP) begin
      r = letter_rom[cp - FIRST_LETTER_CP];
    end
    return r;
  endfunction

  function automatic logic joins_onward(input logic [CP_W-1:0] cp);
    return row_of(cp).cls == LC_DUAL;
  endfunction

  function automatic logic takes_join(input logic [CP_W-1:0] cp);
    letter_cls_e c;
    c = row_of(cp).cls;
    return c == LC_RIGHT || c == LC_DUAL;
  endfunction

  // presentation forms sit at iso, fin = iso+1, ini = iso+2, med = iso+3;
  // right-joining letters only ever reach iso or fin, hamza only iso
  function automatic logic [CP_W-1:0] form_for(input logic [CP_W-1:0] cp,
                                                input logic back_dual,
                                                input logic next_takes);
    letter_t r;
    logic jb;
    logic jf;
    logic [15:0] g;
    r = row_of(cp);
    if (r.cls == LC_NOT) begin
      return cp;
    end
    jb = back_dual && r.cls != LC_NONE;
    jf = next_takes && r.cls == LC_DUAL;
    if (jb && jf) begin
      g = r.iso + 16'd3;
    end else if (jb) begin
      g = r.iso + 16'd1;
    end else if (jf) begin
      g = r.iso + 16'd2;
    end else begin
      g = r.iso;
    end
    return {{(CP_W-16){1'b0}}, g};
  endfunction

  function automatic int alef_slot(input logic [CP_W-1:0] cp);
    case (cp)
      ALEF_MADDA_CP:       return 0;
      ALEF_HAMZA_ABOVE_CP: return 1;
      ALEF_HAMZA_BELOW_CP: return 2;
      ALEF_CP:             return 3;
      default:             return -1;
    endcase
  endfunction

  // advance the context by one code point, returning up to two glyphs
  task automatic shape_step(input logic [CP_W-1:0] cp, input logic last,
                            output glyph_beat_t g0, output glyph_beat_t g1,
                            output int n);
    int slot;
    logic [CP_W-1:0] lig;
    logic merged;
    g0 = '0;
    g1 = '0;
    n = 0;
    merged = 1'b0;
    if (held_busy) begin
      slot = (held_cp == LAM_CP) ? alef_slot(cp) : -1;
      if (slot >= 0) begin
        lig = {{(CP_W-16){1'b0}}, LIGATURE_FIRST};
        lig = lig + CP_W'(2 * slot) + CP_W'(prev_joins);
        g0 = {lig, last};
        n = 1;
        held_busy = 1'b0;
        held_cp = '0;
        prev_joins = last ? 1'b0 : joins_onward(cp);
        merged = 1'b1;
      end else begin
        g0 = {form_for(held_cp, prev_joins, takes_join(cp)), 1'b0};
        n = 1;
        prev_joins = joins_onward(held_cp);
      end
    end
    if (!merged) begin
      if (last) begin
        if (n == 0) begin
          g0 = {form_for(cp, prev_joins, 1'b0), 1'b1};
        end else begin
          g1 = {form_for(cp, prev_joins, 1'b0), 1'b1};
        end
        n++;
        held_busy = 1'b0;
        held_cp = '0;
        prev_joins = 1'b0;
      end else begin
        held_cp = cp;
        held_busy = 1'b1;
      end
    end
  endtask

  task automatic send_beat(input logic [CP_W-1:0] cp, input logic last,
                           input logic has_want, input glyph_beat_t want);
    glyph_beat_t g0;
    glyph_beat_t g1;
    int n;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_point_i <= cp;
    last_in_string_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shape_step(cp, last, g0, g1, n);
    if (has_want) begin
      expected_glyphs.push_back(want);
    end else begin
      if (n > 0) expected_glyphs.push_back(g0);
      if (n > 1) expected_glyphs.push_back(g1);
    end
  endtask

  function automatic logic [CP_W-1:0] alef_pick();
    case ($urandom_range(3))
      0:       return ALEF_MADDA_CP;
      1:       return ALEF_HAMZA_ABOVE_CP;
      2:       return ALEF_HAMZA_BELOW_CP;
      default: return ALEF_CP;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] random_code();
    int k;
    k = $urandom_range(99);
    if (k < 60) return letter_bases[$urandom_range(letter_bases.size() - 1)];
    if (k < 72) return LAM_CP;
    if (k < 80) return alef_pick();
    if (k < 88) return CP_W'($urandom_range(21'h0006FF, 21'h000600));
    if (k < 94) return CP_W'($urandom_range(127));
    return CP_W'($urandom);
  endfunction

  // mostly short strings, now and then a long one; lam is often followed by alef
  task automatic send_random_string(inout int sent);
    int len;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] prev;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    prev = '0;
    for (int i = 0; i < len; i++) begin
      if (prev == LAM_CP && $urandom_range(1) == 1) begin
        cp = alef_pick();
      end else begin
        cp = random_code();
      end
      send_beat(cp, i == len - 1, 1'b0, '0);
      prev = cp;
      sent++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : glyph_check
    glyph_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_glyphs.size() == 0) begin
        $display("%0t: unexpected glyph beat glyph=%h eos=%b", $time,
                 glyph_code_o, end_of_string_o);
        mismatches++;
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_code_o !== want.glyph) begin
          $display("%0t: glyph_code expected %h actual %h", $time, want.glyph,
                   glyph_code_o);
          mismatches++;
        end
        if (end_of_string_o !== want.eos) begin
          $display("%0t: end_of_string expected %b actual %b", $time, want.eos,
                   end_of_string_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int sent;
    for (int i = 0; i < 42; i++) begin
      letter_rom[i].cls = LC_NOT;
      letter_rom[i].iso = '0;
    end
    rom_row(21'h000621, LC_NONE,  16'hFE80);
    rom_row(21'h000622, LC_RIGHT, 16'hFE81);
    rom_row(21'h000623, LC_RIGHT, 16'hFE83);
    rom_row(21'h000624, LC_RIGHT, 16'hFE85);
    rom_row(21'h000625, LC_RIGHT, 16'hFE87);
    rom_row(21'h000626, LC_DUAL,  16'hFE89);
    rom_row(21'h000627, LC_RIGHT, 16'hFE8D);
    rom_row(21'h000628, LC_DUAL,  16'hFE8F);
    rom_row(21'h000629, LC_RIGHT, 16'hFE93);
    rom_row(21'h00062A, LC_DUAL,  16'hFE95);
    rom_row(21'h00062B, LC_DUAL,  16'hFE99);
    rom_row(21'h00062C, LC_DUAL,  16'hFE9D);
    rom_row(21'h00062D, LC_DUAL,  16'hFEA1);
    rom_row(21'h00062E, LC_DUAL,  16'hFEA5);
    rom_row(21'h00062F, LC_RIGHT, 16'hFEA9);
    rom_row(21'h000630, LC_RIGHT, 16'hFEAB);
    rom_row(21'h000631, LC_RIGHT, 16'hFEAD);
    rom_row(21'h000632, LC_RIGHT, 16'hFEAF);
    rom_row(21'h000633, LC_DUAL,  16'hFEB1);
    rom_row(21'h000634, LC_DUAL,  16'hFEB5);
    rom_row(21'h000635, LC_DUAL,  16'hFEB9);
    rom_row(21'h000636, LC_DUAL,  16'hFEBD);
    rom_row(21'h000637, LC_DUAL,  16'hFEC1);
    rom_row(21'h000638, LC_DUAL,  16'hFEC5);
    rom_row(21'h000639, LC_DUAL,  16'hFEC9);
    rom_row(21'h00063A, LC_DUAL,  16'hFECD);
    rom_row(21'h000641, LC_DUAL,  16'hFED1);
    rom_row(21'h000642, LC_DUAL,  16'hFED5);
    rom_row(21'h000643, LC_DUAL,  16'hFED9);
    rom_row(21'h000644, LC_DUAL,  16'hFEDD);
    rom_row(21'h000645, LC_DUAL,  16'hFEE1);
    rom_row(21'h000646, LC_DUAL,  16'hFEE5);
    rom_row(21'h000647, LC_DUAL,  16'hFEE9);
    rom_row(21'h000648, LC_RIGHT, 16'hFEED);
    rom_row(21'h000649, LC_RIGHT, 16'hFEEF);
    rom_row(21'h00064A, LC_DUAL,  16'hFEF1);
    for (int cp = FIRST_LETTER_CP; cp <= LAST_LETTER_CP; cp++) begin
      if (row_of(CP_W'(cp)).cls != LC_NOT) letter_bases.push_back(CP_W'(cp));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 25; r++) begin
      send_beat(DIRECTED[r].cp, DIRECTED[r].last, DIRECTED[r].has_want,
                {DIRECTED[r].glyph, DIRECTED[r].eos});
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = SRC_PCT[p];
      snk_stall_pct = SNK_PCT[p];
      // long receiver hold-off so the block backs up and stalls its input
      if (p == 0 || p == 2) hold_req++;
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_string(sent);
    end

    in_valid_i <= 1'b0;
    snk_stall_pct = 0;
    while (expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
